>>> rtl/bilinear_image_rotator_assert.svh
// assertion macros for the bilinear image rotator
`ifndef BILINEAR_IMAGE_ROTATOR_ASSERT_SVH
`define BILINEAR_IMAGE_ROTATOR_ASSERT_SVH

// condition in the same cycle
`define BIROT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("birot assertion failed");

// condition in the following cycle
`define BIROT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("birot assertion failed");

`endif

>>> rtl/birot_pkg.sv
package birot_pkg;

    // default store side and blend weight precision
    localparam int MAX_SIDE_DEF    = 256;
    localparam int WEIGHT_BITS_DEF = 8;

    // register reset values
    localparam logic [8:0]  SRC_W_RST  = 9'd256;
    localparam logic [8:0]  SRC_H_RST  = 9'd256;
    localparam logic [8:0]  OUT_S_RST  = 9'd363;
    localparam logic [15:0] COS_RST    = 16'sd16384;
    localparam logic [15:0] SIN_RST    = 16'sd0;

    // angle fraction bits
    localparam int ANG_FRAC = 14;

    typedef enum logic [2:0] {
        CFG_SRC_W = 3'd0,
        CFG_SRC_H = 3'd1,
        CFG_OUT_S = 3'd2,
        CFG_COS   = 3'd3,
        CFG_SIN   = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

endpackage

>>> rtl/birot_bank.sv
module birot_bank import birot_pkg::*; #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bilinear_image_rotator.sv
// Bilinear image rotator.
// Input channel (i_valid / o_stall) carries words with an opcode: a load word
// writes i_pixel_in at (i_pos_x, i_pos_y) of the source store and gives no
// result; a query word asks for pixel (i_pos_x, i_pos_y) of the rotated square
// output and gives exactly one result word on o_valid / i_stall.
// Configuration goes over i_cfg_valid / o_cfg_ready (always ready); the user writes it
// while the block is idle (not enforced); a write takes effect on the next word.
// The source store is four banks split by column and row parity, so the four
// neighbours of a query are read at the same time.
// Throughput is one word per cycle while the receiver does not stall, loads
// and queries freely mixed, set by the single read of each bank per cycle;
// a load is seen by any later query.
// Reset clears the pipeline valids and loads the register defaults; the
// source store is not cleared and holds no defined data until written.
// When the receiver stalls a valid result the whole pipeline holds, o_stall
// rises in the same cycle, so no word is lost; the result register holds its word.
module bilinear_image_rotator import birot_pkg::*; #(
    parameter int MAX_SIDE    = MAX_SIDE_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [8:0]  i_pos_x,
    input  logic [8:0]  i_pos_y,
    input  logic [31:0] i_pixel_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_pixel_out,
    output logic        o_in_range,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

`include "bilinear_image_rotator_assert.svh"

    localparam int WB    = WEIGHT_BITS;
    localparam int CW    = $clog2(MAX_SIDE);
    localparam int HALF  = (MAX_SIDE + 1) / 2;
    localparam int DEPTH = HALF * HALF;
    localparam int BA    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = 30;
    localparam int LS    = (WB > ANG_FRAC) ? (WB - ANG_FRAC) : 0;
    localparam int RS    = (WB > ANG_FRAC) ? 0 : (ANG_FRAC - WB);
    localparam int PW    = SW + LS;
    localparam logic [PW-1:0] RND = (RS > 0) ? (PW'(1) << (RS - 1)) : '0;
    localparam logic [WB:0] ONE_W = (WB + 1)'(1) << WB;
    localparam int TW    = WB + 9;
    localparam int VW    = 2 * WB + 9;
    localparam logic [VW-1:0] VRND = VW'(1) << (2 * WB - 1);

    // configuration registers
    logic [8:0]         r_src_w, r_src_h, r_out_s;
    logic signed [15:0] r_cos, r_sin;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SRC_W_RST;
            r_src_h <= SRC_H_RST;
            r_out_s <= OUT_S_RST;
            r_cos   <= COS_RST;
            r_sin   <= SIN_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SRC_W: r_src_w <= i_cfg_data[8:0];
                CFG_SRC_H: r_src_h <= i_cfg_data[8:0];
                CFG_OUT_S: r_out_s <= i_cfg_data[8:0];
                CFG_COS:   r_cos   <= i_cfg_data;
                CFG_SIN:   r_sin   <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // pipeline advance
    logic w_en;
    logic r_out_valid;
    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;

    // stage 1: offsets from the output centre
    logic               r1_valid, r1_op, r1_inr, r1_stok;
    logic signed [9:0]  r1_cx, r1_cy;
    logic [CW-1:0]      r1_x, r1_y;
    logic [31:0]        r1_pix;
    logic [8:0]         w_half;
    assign w_half = r_out_s >> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_op   <= i_opcode;
            r1_inr  <= (i_pos_x < r_out_s) && (i_pos_y < r_out_s);
            r1_stok <= (int'(i_pos_x) < MAX_SIDE) && (int'(i_pos_y) < MAX_SIDE);
            r1_cx   <= $signed({1'b0, i_pos_x}) - $signed({1'b0, w_half});
            r1_cy   <= $signed({1'b0, w_half}) - $signed({1'b0, i_pos_y});
            r1_x    <= CW'(i_pos_x);
            r1_y    <= CW'(i_pos_y);
            r1_pix  <= i_pixel_in;
        end
    end

    // stage 2: rotation products
    logic               r2_valid, r2_op, r2_inr, r2_stok;
    logic signed [25:0] r2_pxc, r2_pys, r2_pyc, r2_pxs;
    logic [CW-1:0]      r2_x, r2_y;
    logic [31:0]        r2_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_op   <= r1_op;
            r2_inr  <= r1_inr;
            r2_stok <= r1_stok;
            r2_pxc  <= r1_cx * r_cos;
            r2_pys  <= r1_cy * r_sin;
            r2_pyc  <= r1_cy * r_cos;
            r2_pxs  <= r1_cx * r_sin;
            r2_x    <= r1_x;
            r2_y    <= r1_y;
            r2_pix  <= r1_pix;
        end
    end

    // stage 3: source position, weights and neighbour bounds
    logic [8:0]           w_w, w_h;
    logic signed [SW-1:0] w_sx, w_sy;
    logic signed [PW-1:0] w_sxr, w_syr, w_fx, w_fy, w_cxl, w_cyl, w_wx, w_hx;
    logic [WB-1:0]        w_dx, w_dy;
    logic                 w_black;

    always_comb begin
        w_w   = (int'(r_src_w) > MAX_SIDE) ? 9'(MAX_SIDE) : r_src_w;
        w_h   = (int'(r_src_h) > MAX_SIDE) ? 9'(MAX_SIDE) : r_src_h;
        w_sx  = SW'(r2_pxc) + SW'(r2_pys) + (SW'(w_w >> 1) <<< ANG_FRAC);
        w_sy  = (SW'(w_h >> 1) <<< ANG_FRAC) - (SW'(r2_pyc) - SW'(r2_pxs));
        w_sxr = ((PW'(w_sx) + $signed(RND)) >>> RS) <<< LS;
        w_syr = ((PW'(w_sy) + $signed(RND)) >>> RS) <<< LS;
        w_fx  = w_sxr >>> WB;
        w_fy  = w_syr >>> WB;
        w_dx  = w_sxr[WB-1:0];
        w_dy  = w_syr[WB-1:0];
        w_cxl = w_fx + PW'(w_dx != '0);
        w_cyl = w_fy + PW'(w_dy != '0);
        w_wx  = PW'(w_w);
        w_hx  = PW'(w_h);
        w_black = !r2_inr || w_fx[PW-1] || w_fy[PW-1] || (w_cxl >= w_wx) || (w_cyl >= w_hx);
    end

    logic          r3_valid, r3_op, r3_inr, r3_black, r3_stok;
    logic [CW-1:0] r3_fx, r3_fy, r3_cxl, r3_cyl, r3_x, r3_y;
    logic [WB-1:0] r3_dx, r3_dy;
    logic [31:0]   r3_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_op    <= r2_op;
            r3_inr   <= r2_inr;
            r3_black <= w_black;
            r3_stok  <= r2_stok;
            r3_fx    <= CW'(w_fx);
            r3_fy    <= CW'(w_fy);
            r3_cxl   <= CW'(w_cxl);
            r3_cyl   <= CW'(w_cyl);
            r3_dx    <= w_dx;
            r3_dy    <= w_dy;
            r3_x     <= r2_x;
            r3_y     <= r2_y;
            r3_pix   <= r2_pix;
        end
    end

    // parity banks: loads write and queries read at this stage, in order
    logic [3:0]    w_we;
    logic [BA-1:0] w_waddr;
    logic [BA-1:0] w_raddr [4];
    logic [31:0]   w_rdata [4];

    assign w_waddr = BA'(int'(r3_y >> 1) * HALF + int'(r3_x >> 1));

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [CW-1:0] w_col, w_row;
        assign w_col = (r3_fx[0] == b[0]) ? r3_fx : r3_cxl;
        assign w_row = (r3_fy[0] == b[1]) ? r3_fy : r3_cyl;
        assign w_raddr[b] = BA'(int'(w_row >> 1) * HALF + int'(w_col >> 1));
        assign w_we[b] = w_en && r3_valid && (r3_op == OP_LOAD) && r3_stok
                         && (r3_x[0] == b[0]) && (r3_y[0] == b[1]);

        birot_bank #(
            .DEPTH (DEPTH),
            .AW    (BA)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (w_we[b]),
            .i_waddr (w_waddr),
            .i_wdata (r3_pix),
            .i_re    (w_en),
            .i_raddr (w_raddr[b]),
            .o_rdata (w_rdata[b])
        );
    end

    // stage 4: neighbour words arrive
    logic          r4_valid, r4_inr, r4_black;
    logic          r4_fx0, r4_fy0, r4_cx0, r4_cy0;
    logic [WB-1:0] r4_dx, r4_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_en) begin
            r4_valid <= r3_valid && (r3_op == OP_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_inr   <= r3_inr;
            r4_black <= r3_black;
            r4_fx0   <= r3_fx[0];
            r4_fy0   <= r3_fy[0];
            r4_cx0   <= r3_cxl[0];
            r4_cy0   <= r3_cyl[0];
            r4_dx    <= r3_dx;
            r4_dy    <= r3_dy;
        end
    end

    logic [31:0] w_tl, w_tr, w_bl, w_br;
    assign w_tl = w_rdata[{r4_fy0, r4_fx0}];
    assign w_tr = w_rdata[{r4_fy0, r4_cx0}];
    assign w_bl = w_rdata[{r4_cy0, r4_fx0}];
    assign w_br = w_rdata[{r4_cy0, r4_cx0}];

    // stage 5: horizontal blend per channel
    logic          r5_valid, r5_inr, r5_black;
    logic [WB-1:0] r5_dy;
    logic [TW-1:0] r5_top [4];
    logic [TW-1:0] r5_bot [4];
    logic [WB:0]   w_mdx, w_dxw;
    assign w_mdx = ONE_W - (WB + 1)'(r4_dx);
    assign w_dxw = (WB + 1)'(r4_dx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (w_en) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_inr   <= r4_inr;
            r5_black <= r4_black;
            r5_dy    <= r4_dy;
            for (int c = 0; c < 4; c++) begin
                r5_top[c] <= TW'(w_mdx * TW'(w_tl[c*8 +: 8])) + TW'(w_dxw * TW'(w_tr[c*8 +: 8]));
                r5_bot[c] <= TW'(w_mdx * TW'(w_bl[c*8 +: 8])) + TW'(w_dxw * TW'(w_br[c*8 +: 8]));
            end
        end
    end

    // output stage: vertical blend, rounding and clamp
    logic [WB:0]   w_mdy, w_dyw;
    logic [31:0]   w_pix;
    logic [VW-1:0] w_v [4];
    logic [VW-1:0] w_q [4];
    assign w_mdy = ONE_W - (WB + 1)'(r5_dy);
    assign w_dyw = (WB + 1)'(r5_dy);

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_v[c] = VW'(w_mdy * VW'(r5_top[c])) + VW'(w_dyw * VW'(r5_bot[c])) + VRND;
            w_q[c] = w_v[c] >> (2 * WB);
            w_pix[c*8 +: 8] = (w_q[c] > VW'(255)) ? 8'hFF : w_q[c][7:0];
        end
    end

    logic [31:0] r_pixel_out;
    logic        r_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pixel_out <= r5_black ? 32'd0 : w_pix;
            r_in_range  <= r5_inr;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pixel_out = r_pixel_out;
    assign o_in_range  = r_in_range;

    // checks
    `BIROT_ASSERT_NOW(a_oor_black, o_valid && !o_in_range, o_pixel_out == 32'd0)
    `BIROT_ASSERT_NEXT(a_stall_hold, o_valid && i_stall, o_valid && $stable(o_pixel_out))
    `BIROT_ASSERT_NOW(a_one_bank_write, 1'b1, $onehot0(w_we))
    `BIROT_ASSERT_NOW(a_no_write_stalled, !w_en, w_we == 4'd0)

endmodule

>>> verif/birot_checker.sv
// watches the word and register channels, predicts rotated pixels, compares
module birot_checker import birot_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic        i_opcode,
    input  logic [8:0]  i_pos_x,
    input  logic [8:0]  i_pos_y,
    input  logic [31:0] i_pixel_in,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic [31:0] i_pixel_out,
    input  logic        i_in_range,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] pixel;
        logic        in_range;
    } t_rot_pixel;

    logic [31:0]        src_image [0:65535];
    logic [8:0]         src_w, src_h, out_side;
    logic signed [15:0] cos_q, sin_q;
    t_rot_pixel         pixel_queue [$];

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        o_errors++;
    endtask

    // inverse rotation, neighbour fetch and bilinear blend
    function automatic t_rot_pixel rotate_pixel(input logic [8:0] x, input logic [8:0] y);
        t_rot_pixel r;
        longint w, h, half, cx, cy, sx, sy, fx, fy, dx, dy, cxl, cyl;
        longint a, b, c, d, top, bot, v;
        logic [31:0] tl, tr, bl, br;
        r = '0;
        if (x >= out_side || y >= out_side) return r;
        r.in_range = 1'b1;
        w = (src_w > 256) ? 256 : src_w;
        h = (src_h > 256) ? 256 : src_h;
        half = out_side / 2;
        cx = longint'(x) - half;
        cy = half - longint'(y);
        sx = cx * cos_q + cy * sin_q + (w / 2) * 16384;
        sy = (h / 2) * 16384 - (cy * cos_q - cx * sin_q);
        // q.14 down to 8 weight bits, round half up
        sx = (sx + 32) >>> 6;
        sy = (sy + 32) >>> 6;
        fx = sx >>> 8;
        fy = sy >>> 8;
        dx = sx & 255;
        dy = sy & 255;
        cxl = fx + (dx != 0);
        cyl = fy + (dy != 0);
        // any neighbour off the source gives black
        if (fx < 0 || fy < 0 || cxl >= w || cyl >= h) return r;
        tl = src_image[fy * 256 + fx];
        tr = src_image[fy * 256 + cxl];
        bl = src_image[cyl * 256 + fx];
        br = src_image[cyl * 256 + cxl];
        for (int ch = 0; ch < 4; ch++) begin
            a = tl[ch*8 +: 8];
            b = tr[ch*8 +: 8];
            c = bl[ch*8 +: 8];
            d = br[ch*8 +: 8];
            top = (256 - dx) * a + dx * b;
            bot = (256 - dx) * c + dx * d;
            v = ((256 - dy) * top + dy * bot + 32768) >> 16;
            if (v > 255) v = 255;
            r.pixel[ch*8 +: 8] = v[7:0];
        end
        return r;
    endfunction

    assign o_pending = pixel_queue.size();

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_rot_pixel exp_px;
        if (!i_rst_n) begin
            src_w    <= SRC_W_RST;
            src_h    <= SRC_H_RST;
            out_side <= OUT_S_RST;
            cos_q    <= COS_RST;
            sin_q    <= SIN_RST;
            pixel_queue.delete();
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SRC_W: src_w    <= i_cfg_data[8:0];
                    CFG_SRC_H: src_h    <= i_cfg_data[8:0];
                    CFG_OUT_S: out_side <= i_cfg_data[8:0];
                    CFG_COS:   cos_q    <= i_cfg_data;
                    CFG_SIN:   sin_q    <= i_cfg_data;
                    default: ;
                endcase
            end
            // accepted input word
            if (i_valid && !i_stall_in) begin
                if (t_op'(i_opcode) == OP_LOAD) begin
                    if (i_pos_x < 256 && i_pos_y < 256)
                        src_image[i_pos_y * 256 + i_pos_x] = i_pixel_in;
                end else begin
                    pixel_queue.push_back(rotate_pixel(i_pos_x, i_pos_y));
                end
            end
            // accepted result word
            if (i_res_valid && !i_res_stall) begin
                if (pixel_queue.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    exp_px = pixel_queue.pop_front();
                    if (i_pixel_out !== exp_px.pixel)
                        report_mismatch($sformatf("pixel_out %h expected %h",
                                                  i_pixel_out, exp_px.pixel));
                    if (i_in_range !== exp_px.in_range)
                        report_mismatch($sformatf("in_range %b expected %b",
                                                  i_in_range, exp_px.in_range));
                end
            end
        end
    end
endmodule

>>> verif/tb_top.sv
module tb_top;
    import birot_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 5000;
    // side of the corner of the store that is loaded before any query
    localparam int FILL = 16;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_stall, i_opcode, o_valid, i_stall, o_in_range;
    logic [8:0]  i_pos_x, i_pos_y;
    logic [31:0] i_pixel_in, o_pixel_out;
    logic        i_cfg_valid, o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    int          errors, pending, send_idle_pct, recv_stall_pct, quiet_cycles;

    bilinear_image_rotator dut (.*);

    birot_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_opcode, .i_pos_x,
        .i_pos_y, .i_pixel_in, .i_res_valid(o_valid), .i_res_stall(i_stall),
        .i_pixel_out(o_pixel_out), .i_in_range(o_in_range), .i_cfg_valid,
        .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver stalls at random
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_word(input t_op op, input logic [8:0] x, input logic [8:0] y,
                             input logic [31:0] pix);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_opcode   <= op;
        i_pos_x    <= x;
        i_pos_y    <= y;
        i_pixel_in <= pix;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic settle_pipeline();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] data);
        bit taken;
        settle_pipeline();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_rotation(input logic [15:0] c, input logic [15:0] s);
        write_reg(CFG_COS, c);
        write_reg(CFG_SIN, s);
    endtask

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            3: return 16'h7fff;
            4: return 16'h8000;
            default: return 16'($urandom_range(32768) - 16384);
        endcase
    endfunction

    function automatic logic [8:0] pick_side(input int hi);
        case ($urandom_range(5))
            0: return 9'd1;
            1: return 9'(hi);
            2: return 9'($urandom_range(511));
            default: return 9'($urandom_range(hi, 1));
        endcase
    endfunction

    // source sides stay within the loaded corner, zero included
    function automatic logic [8:0] pick_src();
        return 9'($urandom_range(FILL));
    endfunction

    initial begin
        logic [8:0] side;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_opcode = OP_LOAD;
        i_pos_x = '0;
        i_pos_y = '0;
        i_pixel_in = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SRC_W;
        i_cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        quiet_cycles = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the corner that every query below stays inside
        for (int yy = 0; yy < FILL; yy++)
            for (int xx = 0; xx < FILL; xx++)
                send_word(OP_LOAD, 9'(xx), 9'(yy), (xx == yy) ? 32'hffffffff : $urandom());

        // directed: reset setting, corners, outside square, ignored loads
        send_word(OP_QUERY, 9'd0, 9'd0, '0);
        send_word(OP_QUERY, 9'd60, 9'd60, 32'hffffffff);
        send_word(OP_QUERY, 9'd362, 9'd362, '0);
        send_word(OP_QUERY, 9'd363, 9'd0, '0);
        send_word(OP_QUERY, 9'd511, 9'd511, '0);
        send_word(OP_LOAD, 9'd300, 9'd5, 32'h12345678);
        send_word(OP_LOAD, 9'd5, 9'd511, 32'h87654321);
        send_word(OP_QUERY, 9'd53, 9'd53, '0);
        // small source and output for the angle cases
        write_reg(CFG_SRC_W, 16'd16);
        write_reg(CFG_SRC_H, 16'd16);
        write_reg(CFG_OUT_S, 16'd23);
        // half turn, quarter turn, diagonal and out-of-range angles
        set_rotation(-16'sd16384, 16'sd0);
        send_word(OP_QUERY, 9'd10, 9'd15, '0);
        set_rotation(16'sd0, -16'sd16384);
        send_word(OP_QUERY, 9'd12, 9'd6, '0);
        set_rotation(16'sd11585, 16'sd11585);
        send_word(OP_QUERY, 9'd11, 9'd11, '0);
        send_word(OP_QUERY, 9'd5, 9'd14, '0);
        set_rotation(16'h8000, 16'h7fff);
        send_word(OP_QUERY, 9'd11, 9'd11, '0);
        // zero, tiny and oversized source, tiny and largest output
        write_reg(CFG_SRC_W, 16'd0);
        send_word(OP_QUERY, 9'd11, 9'd11, '0);
        write_reg(CFG_SRC_W, 16'd1);
        write_reg(CFG_SRC_H, 16'd1);
        write_reg(CFG_OUT_S, 16'd1);
        set_rotation(16'sd16384, 16'sd0);
        send_word(OP_QUERY, 9'd0, 9'd0, '0);
        send_word(OP_QUERY, 9'd1, 9'd0, '0);
        write_reg(CFG_SRC_W, 16'd511);
        write_reg(CFG_SRC_H, 16'd300);
        write_reg(CFG_OUT_S, 16'd511);
        send_word(OP_QUERY, 9'd135, 9'd135, '0);
        send_word(OP_QUERY, 9'd510, 9'd510, '0);

        // random phases with fresh settings and idling modes
        for (int ph = 0; ph < 12; ph++) begin
            side = pick_side(24);
            write_reg(CFG_SRC_W, 16'(pick_src()));
            write_reg(CFG_SRC_H, 16'(pick_src()));
            write_reg(CFG_OUT_S, 16'(side));
            set_rotation(pick_angle(), pick_angle());
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            for (int n = 0; n < 80; n++) begin
                if ($urandom_range(99) < 30)
                    send_word(OP_LOAD, 9'($urandom_range(511)), 9'($urandom_range(511)),
                              $urandom());
                else if ($urandom_range(9) == 0 || side == 0)
                    send_word(OP_QUERY, 9'($urandom_range(511)), 9'($urandom_range(511)),
                              $urandom());
                else
                    send_word(OP_QUERY, 9'($urandom_range(side - 1)),
                              9'($urandom_range(side - 1)), $urandom());
            end
        end

        settle_pipeline();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

>>> bilinear_image_rotator.f
+incdir+rtl
rtl/birot_pkg.sv
rtl/birot_bank.sv
rtl/bilinear_image_rotator.sv
verif/birot_checker.sv
verif/tb_top.sv
